@@ hdl/grid_ray_wall_caster_top_assert.svh @@
// Assertion macros for the grid ray wall caster.
// Each macro expects clk and arst_n in scope.
`ifndef GRID_RAY_WALL_CASTER_TOP_ASSERT_SVH
`define GRID_RAY_WALL_CASTER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/grc_pkg.sv @@
package grc_pkg;

	localparam int MAP_W       = 64;
	localparam int MAP_H       = 64;
	localparam int CELL_SZ     = 64;
	localparam int ANGLE_STEPS = 4096;

	localparam int ANG_W       = $clog2(ANGLE_STEPS);
	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CELL_W      = 8;
	localparam int CFG_W       = 20;
	localparam int CS_LOG      = $clog2(CELL_SZ) + 8;
	localparam int COL_W       = $clog2(MAP_W);
	localparam int ROW_W       = $clog2(MAP_H);
	localparam int DIFF_W      = CS_LOG + 2;
	localparam int POS_W       = 48;
	localparam int TRIG_W      = 32;
	localparam int DIV_W       = 48;
	localparam int DIST_W      = 24;
	localparam int SQ_W        = 2 * DIST_W + 2;
	localparam int CORDIC_STEPS = 30;
	localparam int ITER_W      = $clog2(CORDIC_STEPS);
	localparam int STEP_LIMIT  = MAP_W + MAP_H + 4;
	localparam int STEP_W      = $clog2(STEP_LIMIT + 1);

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [POS_W-1:0]  pos_t;

	localparam trig_t CORDIC_GAIN = 32'sd652032874;
	localparam trig_t TRIG_EPS    = 32'sd16384;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_CAST  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_VIEWER_X   = 2'd0,
		CFG_VIEWER_Y   = 2'd1,
		CFG_VIEW_ANGLE = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_TRIG, ST_TRIG_WAIT,
		ST_AX_SETUP, ST_AX_MUL, ST_AX_DIV, ST_AX_WAIT,
		ST_MARCH_CHK, ST_MARCH_RD,
		ST_DIST_SQ, ST_DIST_SUM, ST_DIST_SQRT, ST_DIST_FIN,
		ST_AX_END, ST_PICK, ST_CORR, ST_CORR_WAIT, ST_CORR_MUL, ST_CORR_FIN, ST_OUT
	} grc_state_t;

	// arctangent of 2^-i in units of 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051D;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/grc_ram.sv @@
module grc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/grc_cordic.sv @@
module grc_cordic import grc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [ANG_W-1:0] angle,
	output logic             done,
	output trig_t            sine,
	output trig_t            cosine
);

	logic                    run_q, done_q, flip_q;
	logic [ITER_W-1:0]       i_q;
	trig_t                   x_q, y_q;
	logic signed [TRIG_W:0]  z_q;
	logic [31:0]             t0, tf;
	logic                    flip0;
	trig_t                   xs, ys;
	logic signed [TRIG_W:0]  at;

	// angle to 2^32 per turn, folded into the right half plane
	assign t0    = {angle, (32 - ANG_W)'(0)};
	assign flip0 = (t0 >= 32'h40000000) && (t0 < 32'hC0000000);
	assign tf    = flip0 ? (t0 - 32'h80000000) : t0;
	assign xs    = x_q >>> i_q;
	assign ys    = y_q >>> i_q;
	assign at    = signed'({1'b0, atan_turn(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == ITER_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'({tf[31], tf});
			flip_q <= flip0;
		end else if (run_q) begin
			if (!z_q[TRIG_W]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done   = done_q;
	assign sine   = flip_q ? -y_q : y_q;
	assign cosine = flip_q ? -x_q : x_q;

endmodule

@@ hdl/grc_div.sv @@
module grc_div import grc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic signed [DIV_W-1:0] dividend,
	input  trig_t                   divisor,
	output logic                    done,
	output logic signed [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic              run_q, done_q, neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  num_q;
	logic [TRIG_W-1:0] den_q, rem_q;
	logic [TRIG_W:0]   rem_sh, rem_sub;
	logic              fits;

	// restoring division on magnitudes, one quotient bit per cycle
	assign rem_sh  = {rem_q, num_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			den_q <= divisor[TRIG_W-1] ? TRIG_W'(-divisor) : TRIG_W'(divisor);
			neg_q <= dividend[DIV_W-1] ^ divisor[TRIG_W-1];
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[TRIG_W-1:0] : rem_sh[TRIG_W-1:0];
			num_q <= {num_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'(num_q) : signed'(num_q);

endmodule

@@ hdl/grid_ray_wall_caster_top.sv @@
// Grid ray wall caster. Map writes (opcode 0) take effect in the cycle they are
// accepted and the block stays free. A cast (opcode 1) keeps busy high while a
// single sequencer works through it: the shared CORDIC for the ray, then per
// axis, unless the ray runs nearly parallel to its grid lines, a setup with
// two passes through the shared divider, a check and a map RAM read per cell
// stepped (at most 132 steps) plus one final check, and the distance with a
// two-bit-per-cycle square root, then, for a wall within range, the CORDIC
// again for the fisheye correction. The result appears with done, high for
// exactly one cycle; it cannot be held off, so a receiver must take it then.
// After reset the map is cleared one cell per cycle, all 4096 cells with busy
// high; configuration writes are taken at any time.
module grid_ray_wall_caster_top import grc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [ADDR_W-1:0]        cell_index,
	input  logic [CELL_W-1:0]        cell_value,
	input  logic [ANG_W-1:0]         ray_angle,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     done,
	output logic [DIST_W-1:0]        wall_distance,
	output logic signed [DIST_W-1:0] hit_x,
	output logic signed [DIST_W-1:0] hit_y,
	output logic                     from_vertical,
	output logic                     left_map
);

	localparam pos_t CELL_UNITS = pos_t'(2 ** CS_LOG);
	localparam pos_t X_LIM      = pos_t'(MAP_W * (2 ** CS_LOG));
	localparam pos_t Y_LIM      = pos_t'(MAP_H * (2 ** CS_LOG));
	localparam int   CPROD_W    = DIST_W + 1 + TRIG_W;

	function automatic logic [DIST_W-1:0] sat24(input pos_t v);
		logic [DIST_W-1:0] r;
		if (v > pos_t'(8388607)) begin
			r = 24'h7FFFFF;
		end else if (v < -pos_t'(8388608)) begin
			r = 24'h800000;
		end else begin
			r = v[DIST_W-1:0];
		end
		return r;
	endfunction

	grc_state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [CFG_W-1:0]  vx_q, vy_q;
	logic [ANG_W-1:0]  va_q, ang_q;
	logic              done_q;

	logic              axis_q, phase_q;
	pos_t              m_q, cr_q, x_q, y_q, dx_q, dy_q;
	logic signed [DIFF_W-1:0] dm_q;
	logic signed [DIV_W-1:0]  prod_q;
	logic [STEP_W-1:0] n_q;
	logic              valid_q, left_q, instore_q;
	logic [DIST_W-1:0] dist_q;
	logic [2*DIST_W-1:0] sqx_q, sqy_q;
	logic [SQ_W-1:0]   v_q, r_q, sq_bit_q;

	pos_t              h_x_q, h_y_q;
	logic [DIST_W-1:0] h_dist_q;
	logic              h_valid_q, h_left_q;

	pos_t              pk_x_q, pk_y_q;
	logic [DIST_W-1:0] pd_q;
	logic              fv_q, lf_q;
	logic signed [CPROD_W-1:0] cprod_q;

	logic [DIST_W-1:0] wall_distance_q;
	logic signed [DIST_W-1:0] hit_x_q, hit_y_q;
	logic              from_vertical_q, left_map_q;

	// shared units
	logic              cor_go, cor_done, div_go, div_done;
	logic [ANG_W-1:0]  cor_angle;
	trig_t             sine, cosine;
	logic signed [DIV_W-1:0] quotient;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	// per-axis selections: "main" is the coordinate that crosses grid lines
	trig_t             tm, to;
	logic [CFG_W-1:0]  pm, pc;
	logic              tm_small;
	pos_t              base;
	logic signed [DIFF_W-1:0] diff, mul_a;
	logic              oob;
	logic [31:0]       cell_lin;
	pos_t              ddx, ddy, ex, ey;
	logic [SQ_W-1:0]   rb;
	logic              use_h;

	assign tm       = axis_q ? cosine : sine;
	assign to       = axis_q ? sine : cosine;
	assign pm       = axis_q ? vx_q : vy_q;
	assign pc       = axis_q ? vy_q : vx_q;
	assign tm_small = (tm <= TRIG_EPS) && (tm >= -TRIG_EPS);
	assign base     = pos_t'({pm[CFG_W-1:CS_LOG], CS_LOG'(0)});
	assign diff     = DIFF_W'(m_q - pos_t'(pm));
	assign mul_a    = phase_q ? dm_q : diff;

	assign oob      = (x_q < 0) || (y_q < 0) || (x_q >= X_LIM) || (y_q >= Y_LIM);
	assign cell_lin = 32'(y_q[CS_LOG +: ROW_W]) * 32'(MAP_W) + 32'(x_q[CS_LOG +: COL_W]);

	assign ddx      = x_q - pos_t'(vx_q);
	assign ddy      = y_q - pos_t'(vy_q);
	assign ex       = ddx[POS_W-1] ? -ddx : ddx;
	assign ey       = ddy[POS_W-1] ? -ddy : ddy;
	assign rb       = r_q + sq_bit_q;
	assign use_h    = (h_dist_q < dist_q) || (!valid_q && h_valid_q);

	grc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cor_go),
		.angle  (cor_angle),
		.done   (cor_done),
		.sine   (sine),
		.cosine (cosine)
	);

	grc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (prod_q),
		.divisor  (tm),
		.done     (div_done),
		.quotient (quotient)
	);

	grc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (STORE_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cor_go    = 1'b0;
		cor_angle = ang_q;
		div_go    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = ADDR_W'(cell_lin);
		ram_wdata = cell_value;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (op_t'(opcode) == OP_WRITE) begin
						ram_we   = 1'b1;
						ram_addr = cell_index;
					end else begin
						state_d = ST_TRIG;
					end
				end
			end
			ST_TRIG: begin
				cor_go  = 1'b1;
				state_d = ST_TRIG_WAIT;
			end
			ST_TRIG_WAIT: begin
				if (cor_done) begin
					state_d = ST_AX_SETUP;
				end
			end
			ST_AX_SETUP: begin
				state_d = tm_small ? ST_AX_END : ST_AX_MUL;
			end
			ST_AX_MUL: begin
				state_d = ST_AX_DIV;
			end
			ST_AX_DIV: begin
				div_go  = 1'b1;
				state_d = ST_AX_WAIT;
			end
			ST_AX_WAIT: begin
				if (div_done) begin
					state_d = phase_q ? ST_MARCH_CHK : ST_AX_MUL;
				end
			end
			ST_MARCH_CHK: begin
				if (n_q == STEP_W'(STEP_LIMIT) || oob) begin
					state_d = ST_DIST_SQ;
				end else begin
					state_d = ST_MARCH_RD;
				end
			end
			ST_MARCH_RD: begin
				state_d = (instore_q && ram_rdata != '0) ? ST_DIST_SQ : ST_MARCH_CHK;
			end
			ST_DIST_SQ: begin
				if (ex[POS_W-1:DIST_W] == '0 && ey[POS_W-1:DIST_W] == '0) begin
					state_d = ST_DIST_SUM;
				end else begin
					state_d = ST_AX_END;
				end
			end
			ST_DIST_SUM: begin
				state_d = ST_DIST_SQRT;
			end
			ST_DIST_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = ST_DIST_FIN;
				end
			end
			ST_DIST_FIN: begin
				state_d = ST_AX_END;
			end
			ST_AX_END: begin
				state_d = axis_q ? ST_PICK : ST_AX_SETUP;
			end
			ST_PICK: begin
				state_d = ((use_h ? h_dist_q : dist_q) < DIST_MAX) ? ST_CORR : ST_OUT;
			end
			ST_CORR: begin
				cor_go    = 1'b1;
				cor_angle = va_q - ang_q;
				state_d   = ST_CORR_WAIT;
			end
			ST_CORR_WAIT: begin
				if (cor_done) begin
					state_d = ST_CORR_MUL;
				end
			end
			ST_CORR_MUL: begin
				state_d = ST_CORR_FIN;
			end
			ST_CORR_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
			vx_q   <= '0;
			vy_q   <= '0;
			va_q   <= '0;
			axis_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_OUT);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_TRIG) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_AX_END) begin
				axis_q <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_VIEWER_X:   vx_q <= cfg_data;
					CFG_VIEWER_Y:   vy_q <= cfg_data;
					CFG_VIEW_ANGLE: va_q <= cfg_data[ANG_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ang_q <= ray_angle;
				end
			end
			ST_AX_SETUP: begin
				phase_q <= 1'b0;
				if (tm_small) begin
					x_q     <= pos_t'(vx_q);
					y_q     <= pos_t'(vy_q);
					dist_q  <= DIST_MAX;
					valid_q <= 1'b0;
					left_q  <= 1'b0;
				end else begin
					m_q  <= tm[TRIG_W-1] ? (base - 1) : (base + CELL_UNITS);
					dm_q <= tm[TRIG_W-1] ? -DIFF_W'(CELL_UNITS) : DIFF_W'(CELL_UNITS);
				end
			end
			ST_AX_MUL: begin
				prod_q <= DIV_W'(mul_a) * DIV_W'(to);
			end
			ST_AX_WAIT: begin
				if (div_done) begin
					if (!phase_q) begin
						cr_q    <= pos_t'(pc) + pos_t'(quotient);
						phase_q <= 1'b1;
					end else begin
						x_q     <= axis_q ? m_q : cr_q;
						y_q     <= axis_q ? cr_q : m_q;
						dx_q    <= axis_q ? pos_t'(dm_q) : pos_t'(quotient);
						dy_q    <= axis_q ? pos_t'(quotient) : pos_t'(dm_q);
						n_q     <= '0;
						valid_q <= 1'b1;
						left_q  <= 1'b1;
					end
				end
			end
			ST_MARCH_CHK: begin
				// maps larger than the store read as empty beyond it
				instore_q <= cell_lin < 32'(STORE_DEPTH);
			end
			ST_MARCH_RD: begin
				if (instore_q && ram_rdata != '0) begin
					left_q <= 1'b0;
				end else begin
					x_q <= x_q + dx_q;
					y_q <= y_q + dy_q;
					n_q <= n_q + 1'b1;
				end
			end
			ST_DIST_SQ: begin
				sqx_q  <= ex[DIST_W-1:0] * ex[DIST_W-1:0];
				sqy_q  <= ey[DIST_W-1:0] * ey[DIST_W-1:0];
				dist_q <= DIST_MAX;
			end
			ST_DIST_SUM: begin
				v_q      <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
				r_q      <= '0;
				sq_bit_q <= SQ_W'(1) << (2 * DIST_W);
			end
			ST_DIST_SQRT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + sq_bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			ST_DIST_FIN: begin
				dist_q <= (r_q > SQ_W'(DIST_MAX)) ? DIST_MAX : r_q[DIST_W-1:0];
			end
			ST_AX_END: begin
				if (!axis_q) begin
					h_x_q     <= x_q;
					h_y_q     <= y_q;
					h_dist_q  <= dist_q;
					h_valid_q <= valid_q;
					h_left_q  <= left_q;
				end
			end
			ST_PICK: begin
				pk_x_q <= use_h ? h_x_q : x_q;
				pk_y_q <= use_h ? h_y_q : y_q;
				pd_q   <= use_h ? h_dist_q : dist_q;
				lf_q   <= use_h ? h_left_q : left_q;
				fv_q   <= !use_h;
			end
			ST_CORR_MUL: begin
				cprod_q <= CPROD_W'(signed'({1'b0, pd_q})) * CPROD_W'(cosine);
			end
			ST_CORR_FIN: begin
				// ray behind the viewer gives zero
				if (cprod_q <= 0) begin
					pd_q <= '0;
				end else if (cprod_q[CPROD_W-1:30] > (CPROD_W - 30)'(DIST_MAX)) begin
					pd_q <= DIST_MAX;
				end else begin
					pd_q <= cprod_q[30 +: DIST_W];
				end
			end
			ST_OUT: begin
				wall_distance_q <= pd_q;
				hit_x_q         <= sat24(pk_x_q);
				hit_y_q         <= sat24(pk_y_q);
				from_vertical_q <= fv_q;
				left_map_q      <= lf_q;
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign wall_distance = wall_distance_q;
	assign hit_x         = hit_x_q;
	assign hit_y         = hit_y_q;
	assign from_vertical = from_vertical_q;
	assign left_map      = left_map_q;

endmodule

@@ hdl/grc_checker.sv @@
`include "grid_ray_wall_caster_top_assert.svh"

module grc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done
);

	`GRC_ASSERT_NEXT(a_cast_goes_busy, start && !busy && opcode, busy, "cast transfer did not start work")

	`GRC_ASSERT_NEXT(a_write_stays_free, start && !busy && !opcode, !busy && !done, "cell write held the block")

	`GRC_ASSERT_NOW(a_done_ends_cast, done, !busy && $past(busy), "result without a cast in flight")

	`GRC_ASSERT_NEXT(a_single_result, done, !done, "result transfer repeated")

endmodule

bind grid_ray_wall_caster_top grc_checker u_grc_checker (.*);
